[rtl/rss_pkg.sv]
// ----------------------------------------------------------------------------
// Robot safety supervisor package
// Shared types, register indexes, codes and the choreography table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rss_pkg;

  localparam int CHOREO_STEPS_DEF   = 10;
  localparam int TICKS_PER_STEP_DEF = 10;

  localparam logic [1:0] REG_BATTERY_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_SENSOR_MASK       = 2'd1;
  localparam logic [1:0] REG_DANGER_NONE       = 2'd2;
  localparam logic [1:0] REG_CHOREO_ENABLE     = 2'd3;

  localparam logic [15:0] BATTERY_THRESHOLD_RST = 16'd10500;
  localparam logic [7:0]  SENSOR_MASK_RST       = 8'hFF;
  localparam logic [15:0] DANGER_NONE_RST       = 16'd0;
  localparam logic        CHOREO_ENABLE_RST     = 1'b1;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_AUTO  = 2'd1,
    MODE_ESTOP = 2'd2,
    MODE_FAULT = 2'd3
  } mode_t;

  localparam logic [1:0] MK_BRAKE = 2'd0;
  localparam logic [1:0] MK_FWD   = 2'd1;
  localparam logic [1:0] MK_REV   = 2'd2;
  localparam logic [1:0] MK_CW    = 2'd3;

  localparam logic [1:0] LED_KEEP  = 2'd0;
  localparam logic [1:0] LED_OFF   = 2'd1;
  localparam logic [1:0] LED_GREEN = 2'd2;
  localparam logic [1:0] LED_RED   = 2'd3;

  localparam logic [6:0] DUTY_ENTRY = 7'd40;
  localparam logic [3:0] STEP_INACTIVE = 4'd15;

  typedef struct packed {
    logic [15:0] battery_threshold_mv;
    logic [7:0]  sensor_block_mask;
    logic [15:0] danger_none_code;
    logic        choreography_enable;
  } cfg_t;

  typedef struct packed {
    logic        start_button;
    logic [7:0]  sensor_bits;
    logic [15:0] battery_mv;
    logic [15:0] danger_flags;
  } req_t;

  typedef struct packed {
    mode_t      mode_now;
    logic       motion_valid;
    logic [1:0] motion_kind;
    logic [6:0] left_duty_pct;
    logic [6:0] right_duty_pct;
    logic [1:0] led_code;
    logic       uv_start;
    logic       uv_stop;
    logic       map_reset;
    logic       low_battery_fault;
    logic [3:0] choreo_step_now;
  } res_t;

  function automatic logic [1:0] chor_kind(input logic [3:0] idx);
    logic [1:0] k;
    case (idx)
      4'd1, 4'd2:       k = MK_REV;
      4'd6, 4'd7, 4'd8: k = MK_CW;
      default:          k = MK_BRAKE;
    endcase
    return k;
  endfunction

  function automatic logic [6:0] chor_duty(input logic [3:0] idx);
    logic [6:0] d;
    case (idx)
      4'd1, 4'd2, 4'd3, 4'd6: d = 7'd30;
      4'd7, 4'd8:             d = 7'd40;
      default:                d = 7'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

[rtl/rss_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Robot safety supervisor configuration registers
// Holds the four settings written through the plain write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rss_cfg_regs
  import rss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.battery_threshold_mv <= BATTERY_THRESHOLD_RST;
      cfg.sensor_block_mask    <= SENSOR_MASK_RST;
      cfg.danger_none_code     <= DANGER_NONE_RST;
      cfg.choreography_enable  <= CHOREO_ENABLE_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_BATTERY_THRESHOLD: cfg.battery_threshold_mv <= cfg_data;
        REG_SENSOR_MASK:       cfg.sensor_block_mask    <= cfg_data[7:0];
        REG_DANGER_NONE:       cfg.danger_none_code     <= cfg_data;
        REG_CHOREO_ENABLE:     cfg.choreography_enable  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/rss_core.sv]
// ----------------------------------------------------------------------------
// Robot safety supervisor core
// Mode and choreography state with the single-pass next-state and action logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rss_core
  import rss_pkg::*;
#(
  parameter int CHOREO_STEPS   = CHOREO_STEPS_DEF,
  parameter int TICKS_PER_STEP = TICKS_PER_STEP_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic fire,
  input  wire cfg_t cfg,
  input  wire req_t req,
  output res_t      res
);

  localparam int STEP_W = $clog2(CHOREO_STEPS + 1);
  localparam int SUB_W  = (TICKS_PER_STEP > 1) ? $clog2(TICKS_PER_STEP) : 1;

  mode_t             mode, mode_next;
  logic              fault, fault_next;
  logic              active, active_next;
  logic [STEP_W-1:0] step, step_next;
  logic [SUB_W-1:0]  sub, sub_next;

  logic       low, blocked, danger_hit, playing, change, in_mode;
  logic [4:0] step_cur_ext, step_next_ext;

  always_comb begin
    low          = req.battery_mv < cfg.battery_threshold_mv;
    blocked      = |(req.sensor_bits & cfg.sensor_block_mask);
    danger_hit   = req.danger_flags != cfg.danger_none_code;
    playing      = active && (step < STEP_W'(CHOREO_STEPS));
    step_cur_ext = 5'(step);

    mode_next   = mode;
    fault_next  = fault;
    active_next = active;
    step_next   = step;
    sub_next    = sub;

    case (mode)
      MODE_IDLE: begin
        if (req.start_button) mode_next = MODE_AUTO;
      end
      MODE_AUTO: begin
        if (req.start_button) begin
          mode_next = MODE_IDLE;
        end else if (low) begin
          fault_next = 1'b1;
          mode_next  = MODE_FAULT;
        end else if (blocked || danger_hit) begin
          mode_next = MODE_ESTOP;
        end
      end
      MODE_ESTOP: begin
        if (req.start_button) begin
          mode_next = MODE_IDLE;
        end else if (low) begin
          fault_next = 1'b1;
          mode_next  = MODE_FAULT;
        end else if (cfg.choreography_enable && playing) begin
          mode_next = MODE_ESTOP;
        end else if (!blocked) begin
          mode_next = MODE_AUTO;
        end
      end
      default: begin
        if (!low) begin
          fault_next = 1'b0;
          mode_next  = MODE_IDLE;
        end
      end
    endcase

    change  = mode_next != mode;
    in_mode = (mode == MODE_ESTOP) && cfg.choreography_enable && playing;

    res = '0;
    res.mode_now = mode_next;

    if (change) begin
      res.map_reset = mode == MODE_IDLE;
      res.uv_stop   = (mode == MODE_AUTO) || (mode == MODE_ESTOP);
      case (mode_next)
        MODE_IDLE: begin
          res.led_code       = LED_OFF;
          res.motion_valid   = 1'b1;
          res.motion_kind    = MK_BRAKE;
          res.left_duty_pct  = DUTY_ENTRY;
          res.right_duty_pct = DUTY_ENTRY;
        end
        MODE_AUTO: begin
          res.led_code       = LED_GREEN;
          res.motion_valid   = 1'b1;
          res.motion_kind    = MK_FWD;
          res.left_duty_pct  = DUTY_ENTRY;
          res.right_duty_pct = DUTY_ENTRY;
          res.uv_start       = 1'b1;
        end
        MODE_ESTOP: begin
          res.led_code = LED_RED;
          if (cfg.choreography_enable) begin
            active_next = 1'b1;
            step_next   = '0;
            sub_next    = '0;
          end else begin
            res.motion_valid   = 1'b1;
            res.motion_kind    = MK_BRAKE;
            res.left_duty_pct  = DUTY_ENTRY;
            res.right_duty_pct = DUTY_ENTRY;
          end
        end
        default: begin
        end
      endcase
    end

    if (in_mode) begin
      res.motion_valid   = 1'b1;
      res.motion_kind    = chor_kind(step_cur_ext[3:0]);
      res.left_duty_pct  = chor_duty(step_cur_ext[3:0]);
      res.right_duty_pct = chor_duty(step_cur_ext[3:0]);
      if (sub == SUB_W'(TICKS_PER_STEP - 1)) begin
        sub_next  = '0;
        step_next = step + STEP_W'(1);
      end else begin
        sub_next = sub + SUB_W'(1);
      end
    end

    step_next_ext         = 5'(step_next);
    res.low_battery_fault = fault_next;
    res.choreo_step_now   = active_next ? step_next_ext[3:0] : STEP_INACTIVE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      fault  <= 1'b0;
      active <= 1'b0;
      step   <= '0;
      sub    <= '0;
    end else if (fire) begin
      mode   <= mode_next;
      fault  <= fault_next;
      active <= active_next;
      step   <= step_next;
      sub    <= sub_next;
    end
  end

endmodule

`default_nettype wire

[rtl/robot_safety_supervisor.sv]
// ----------------------------------------------------------------------------
// Robot safety supervisor
// Four-mode supervisor with entry and exit actions and an e-stop choreography.
// ----------------------------------------------------------------------------
// Each request on the input channel is one supervisor tick carrying the
// button, sensor bits, battery level and danger flags. For every request the
// block returns exactly one result on the output channel: the new mode, the
// last motion command of the tick, LED, UV and map actions, the fault flag
// and the choreography step.
// A request is captured in an input register and evaluated against the mode
// state once the result register can advance, which then loads the result
// register. One request is taken in every cycle while results are drained,
// as the state update is a single pass through the core logic.
// When the receiver stalls, the result register holds its request and the
// input register holds one more; then in_ready falls until the result is
// taken.
// Reset empties both registers, sets idle mode with the choreography inactive
// and loads the configuration defaults. The user must write configuration
// via the plain write port only while no request is in flight; not enforced.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module robot_safety_supervisor
  import rss_pkg::*;
#(
  parameter int CHOREO_STEPS   = CHOREO_STEPS_DEF,
  parameter int TICKS_PER_STEP = TICKS_PER_STEP_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        start_button,
  input  wire logic [7:0]  sensor_bits,
  input  wire logic [15:0] battery_mv,
  input  wire logic [15:0] danger_flags,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       mode_now,
  output logic             motion_valid,
  output logic [1:0]       motion_kind,
  output logic [6:0]       left_duty_pct,
  output logic [6:0]       right_duty_pct,
  output logic [1:0]       led_code,
  output logic             uv_start,
  output logic             uv_stop,
  output logic             map_reset,
  output logic             low_battery_fault,
  output logic [3:0]       choreo_step_now
);

  cfg_t cfg;
  req_t req_in, req;
  res_t res, res_q;
  logic req_valid, advance, fire;

  rss_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  rss_core #(
    .CHOREO_STEPS   (CHOREO_STEPS),
    .TICKS_PER_STEP (TICKS_PER_STEP)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .cfg  (cfg),
    .req  (req),
    .res  (res)
  );

  assign req_in   = '{start_button, sensor_bits, battery_mv, danger_flags};
  assign advance  = !out_valid || out_ready;
  assign fire     = req_valid && advance;
  assign in_ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        req_valid <= 1'b1;
      end else if (advance) begin
        req_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= req_valid;
      end
    end
    if (in_valid && in_ready) begin
      req <= req_in;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  assign mode_now          = res_q.mode_now;
  assign motion_valid      = res_q.motion_valid;
  assign motion_kind       = res_q.motion_kind;
  assign left_duty_pct     = res_q.left_duty_pct;
  assign right_duty_pct    = res_q.right_duty_pct;
  assign led_code          = res_q.led_code;
  assign uv_start          = res_q.uv_start;
  assign uv_stop           = res_q.uv_stop;
  assign map_reset         = res_q.map_reset;
  assign low_battery_fault = res_q.low_battery_fault;
  assign choreo_step_now   = res_q.choreo_step_now;

  a_no_motion_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !motion_valid |->
      motion_kind == MK_BRAKE && left_duty_pct == 7'd0 && right_duty_pct == 7'd0)
    else $error("Motion fields set without a motion command.");

  a_uv_start_auto : assert property (@(posedge clk) disable iff (rst)
    out_valid && uv_start |-> mode_now == MODE_AUTO && (map_reset || uv_stop))
    else $error("UV start outside an entry into autonomy.");

  a_fault_matches_mode : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> low_battery_fault == (mode_now == MODE_FAULT))
    else $error("Fault flag disagrees with the fault mode.");

  a_result_follows_request : assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("Evaluated request did not reach the result register.");

endmodule

`default_nettype wire

[verif/tb_robot_safety_supervisor.sv]
// ----------------------------------------------------------------------------
// Robot safety supervisor testbench
// Drives supervisor ticks through the request channel and checks every result
// against a cycle-free model of the four modes, their entry and exit actions
// and the e-stop choreography. A directed pass covers the battery threshold
// edge, the button priority, sensor and danger triggers and a choreography
// disabled in mid e-stop. Random traffic then follows the modes, mostly with
// well-formed ticks that keep an e-stop running to the end of its
// choreography, under several register settings, idling patterns on both
// channels, a long receiver hold-off and a full drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_robot_safety_supervisor;
  import rss_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 300;

  // Motion table of the choreography, step 0 in the lowest slot.
  localparam logic [31:0] DANCE_KINDS = {
    MK_BRAKE, MK_BRAKE, MK_BRAKE, MK_BRAKE, MK_BRAKE, MK_BRAKE,
    MK_BRAKE, MK_CW, MK_CW, MK_CW, MK_BRAKE, MK_BRAKE, MK_BRAKE, MK_REV, MK_REV, MK_BRAKE
  };
  localparam logic [111:0] DANCE_DUTIES = {
    {6{7'd0}}, 7'd0, 7'd40, 7'd40, 7'd30, 7'd0, 7'd0, 7'd30, 7'd30, 7'd30, 7'd0
  };

  logic        clk;
  logic        rst;
  logic        cfg_write_en;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        start_button;
  logic [7:0]  sensor_bits;
  logic [15:0] battery_mv;
  logic [15:0] danger_flags;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  mode_now;
  logic        motion_valid;
  logic [1:0]  motion_kind;
  logic [6:0]  left_duty_pct;
  logic [6:0]  right_duty_pct;
  logic [1:0]  led_code;
  logic        uv_start;
  logic        uv_stop;
  logic        map_reset;
  logic        low_battery_fault;
  logic [3:0]  choreo_step_now;

  robot_safety_supervisor dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write_en      (cfg_write_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .start_button      (start_button),
    .sensor_bits       (sensor_bits),
    .battery_mv        (battery_mv),
    .danger_flags      (danger_flags),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .mode_now          (mode_now),
    .motion_valid      (motion_valid),
    .motion_kind       (motion_kind),
    .left_duty_pct     (left_duty_pct),
    .right_duty_pct    (right_duty_pct),
    .led_code          (led_code),
    .uv_start          (uv_start),
    .uv_stop           (uv_stop),
    .map_reset         (map_reset),
    .low_battery_fault (low_battery_fault),
    .choreo_step_now   (choreo_step_now)
  );

  // Register copies and supervisor state of the model.
  logic [15:0] lim_batt;
  logic [7:0]  blk_mask;
  logic [15:0] calm_code;
  logic        dance_en;
  mode_t       cur_mode;
  logic        batt_fault;
  logic [15:0] dance_ticks;
  logic [15:0] dance_step;
  logic        dance_on;

  res_t tick_outcomes_q[$];
  int   mismatches;
  int   results_seen;
  int   cycle_count;
  int   send_idle_pct;
  int   recv_idle_pct;
  logic hold_flip;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void model_reset();
    lim_batt    = BATTERY_THRESHOLD_RST;
    blk_mask    = SENSOR_MASK_RST;
    calm_code   = DANGER_NONE_RST;
    dance_en    = CHOREO_ENABLE_RST;
    cur_mode    = MODE_IDLE;
    batt_fault  = 1'b0;
    dance_ticks = '0;
    dance_step  = '0;
    dance_on    = 1'b0;
  endfunction

  function automatic logic dance_playing();
    return dance_on && (dance_step < CHOREO_STEPS_DEF);
  endfunction

  function automatic res_t with_motion(input res_t r, input logic [1:0] kind,
                                       input logic [6:0] left, input logic [6:0] right);
    res_t m;
    m = r;
    m.motion_valid   = 1'b1;
    m.motion_kind    = kind;
    m.left_duty_pct  = left;
    m.right_duty_pct = right;
    return m;
  endfunction

  function automatic res_t supervise_tick(input logic b, input logic [7:0] s,
                                          input logic [15:0] batt, input logic [15:0] dng);
    res_t       r;
    mode_t      was;
    mode_t      nxt;
    logic       low;
    logic       blocked;
    logic [3:0] idx;
    r       = '0;
    was     = cur_mode;
    nxt     = cur_mode;
    low     = (batt < lim_batt);
    blocked = ((s & blk_mask) != 8'd0);
    case (cur_mode)
      MODE_IDLE: begin
        if (b) nxt = MODE_AUTO;
      end
      MODE_AUTO: begin
        if (b) nxt = MODE_IDLE;
        else if (low) begin
          batt_fault = 1'b1;
          nxt = MODE_FAULT;
        end else if (blocked || dng != calm_code) nxt = MODE_ESTOP;
      end
      MODE_ESTOP: begin
        if (b) nxt = MODE_IDLE;
        else if (low) begin
          batt_fault = 1'b1;
          nxt = MODE_FAULT;
        end else if (dance_en && dance_playing()) nxt = MODE_ESTOP;
        else if (!blocked) nxt = MODE_AUTO;
      end
      default: begin
        if (!low) begin
          batt_fault = 1'b0;
          nxt = MODE_IDLE;
        end
      end
    endcase
    if (nxt != was) begin
      if (was == MODE_IDLE) r.map_reset = 1'b1;
      else if (was == MODE_AUTO || was == MODE_ESTOP) r.uv_stop = 1'b1;
      case (nxt)
        MODE_IDLE: begin
          r.led_code = LED_OFF;
          r = with_motion(r, MK_BRAKE, DUTY_ENTRY, DUTY_ENTRY);
        end
        MODE_AUTO: begin
          r.led_code = LED_GREEN;
          r = with_motion(r, MK_FWD, DUTY_ENTRY, DUTY_ENTRY);
          r.uv_start = 1'b1;
        end
        MODE_ESTOP: begin
          r.led_code = LED_RED;
          if (dance_en) begin
            dance_ticks = '0;
            dance_step  = '0;
            dance_on    = 1'b1;
          end else begin
            r = with_motion(r, MK_BRAKE, DUTY_ENTRY, DUTY_ENTRY);
          end
        end
        default: ;
      endcase
      cur_mode = nxt;
    end
    // The in-mode action belongs to the mode held before the tick.
    if (was == MODE_ESTOP && dance_en && dance_playing()) begin
      idx = dance_step[3:0];
      r = with_motion(r, DANCE_KINDS[idx*2 +: 2], DANCE_DUTIES[idx*7 +: 7],
                      DANCE_DUTIES[idx*7 +: 7]);
      dance_ticks = dance_ticks + 16'd1;
      dance_step  = 16'(dance_ticks / TICKS_PER_STEP_DEF);
    end
    r.mode_now          = cur_mode;
    r.low_battery_fault = batt_fault;
    r.choreo_step_now   = dance_on ? dance_step[3:0] : STEP_INACTIVE;
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Result %0d: %s expected %0d, got %0d", results_seen, fname, want, got);
    end
  endtask

  initial begin
    res_t want;
    results_seen = 0;
    mismatches = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (tick_outcomes_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Result %0d arrived with no request waiting", results_seen);
        end else begin
          want = tick_outcomes_q.pop_front();
          check_field("mode_now", 16'(want.mode_now), 16'(mode_now));
          check_field("motion_valid", 16'(want.motion_valid), 16'(motion_valid));
          check_field("motion_kind", 16'(want.motion_kind), 16'(motion_kind));
          check_field("left_duty_pct", 16'(want.left_duty_pct), 16'(left_duty_pct));
          check_field("right_duty_pct", 16'(want.right_duty_pct), 16'(right_duty_pct));
          check_field("led_code", 16'(want.led_code), 16'(led_code));
          check_field("uv_start", 16'(want.uv_start), 16'(uv_start));
          check_field("uv_stop", 16'(want.uv_stop), 16'(uv_stop));
          check_field("map_reset", 16'(want.map_reset), 16'(map_reset));
          check_field("low_battery_fault", 16'(want.low_battery_fault),
                      16'(low_battery_fault));
          check_field("choreo_step_now", 16'(want.choreo_step_now), 16'(choreo_step_now));
        end
        results_seen++;
      end
    end
  end

  // Receiver: random stalls, and a long hold-off each time hold_flip toggles.
  initial begin
    int   hold_left;
    logic hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_flip != hold_seen) begin
        hold_seen = hold_flip;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic odds(input int per_mille);
    return ($urandom_range(0, 999) < per_mille);
  endfunction

  function automatic logic [15:0] healthy_mv();
    return 16'($urandom_range(lim_batt, 65535));
  endfunction

  function automatic logic [15:0] low_mv();
    return (lim_batt == 16'd0) ? 16'd0 : 16'($urandom_range(0, lim_batt - 1));
  endfunction

  function automatic logic [15:0] edge_mv();
    case ($urandom_range(0, 3))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return lim_batt;
      default: return lim_batt - 16'd1;
    endcase
  endfunction

  task automatic send_tick(input logic b, input logic [7:0] s,
                           input logic [15:0] batt, input logic [15:0] dng);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    start_button   <= b;
    sensor_bits    <= s;
    battery_mv     <= batt;
    danger_flags   <= dng;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tick_outcomes_q.push_back(supervise_tick(b, s, batt, dng));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tick_outcomes_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_BATTERY_THRESHOLD: lim_batt  = val;
      REG_SENSOR_MASK:       blk_mask  = val[7:0];
      REG_DANGER_NONE:       calm_code = val;
      default:               dance_en  = val[0];
    endcase
  endtask

  task automatic write_all_regs(input logic [15:0] thr, input logic [7:0] mask,
                                input logic [15:0] none_code, input logic en);
    settle();
    write_reg(REG_BATTERY_THRESHOLD, thr);
    write_reg(REG_SENSOR_MASK, {8'd0, mask});
    write_reg(REG_DANGER_NONE, none_code);
    write_reg(REG_CHOREO_ENABLE, {15'd0, en});
  endtask

  // One tick shaped by the current mode; quiet seldom disturbs a running e-stop.
  task automatic offer_random_tick(input int noise_pm, input logic quiet);
    logic        b;
    logic [7:0]  s;
    logic [15:0] batt;
    logic [15:0] dng;
    b    = 1'b0;
    s    = 8'($urandom);
    batt = healthy_mv();
    dng  = calm_code;
    if (odds(noise_pm)) begin
      b    = 1'($urandom);
      dng  = 16'($urandom);
      batt = odds(200) ? edge_mv() : 16'($urandom);
    end else begin
      case (cur_mode)
        MODE_IDLE: begin
          b   = odds(350);
          dng = 16'($urandom);
        end
        MODE_AUTO: begin
          b = odds(quiet ? 10 : 40);
          if (odds(quiet ? 10 : 50)) batt = odds(300) ? edge_mv() : low_mv();
          if (odds(150)) begin
            if (odds(500)) dng = 16'($urandom);
          end else begin
            s = s & ~blk_mask;
          end
        end
        MODE_ESTOP: begin
          b = odds(quiet ? 3 : 15);
          if (odds(quiet ? 3 : 15)) batt = low_mv();
          if (odds(500)) s = s & ~blk_mask;
          dng = 16'($urandom);
        end
        default: begin
          if (odds(400)) batt = low_mv();
          b   = 1'($urandom);
          dng = 16'($urandom);
        end
      endcase
    end
    send_tick(b, s, batt, dng);
  endtask

  task automatic test_directed_edges();
    send_tick(1'b0, 8'h00, 16'd10500, 16'h0000);
    send_tick(1'b1, 8'h00, 16'd0,     16'hFFFF);
    send_tick(1'b0, 8'h00, 16'd10500, 16'h0000);
    send_tick(1'b0, 8'h00, 16'd10499, 16'h0000);
    send_tick(1'b1, 8'hFF, 16'd10499, 16'hFFFF);
    send_tick(1'b0, 8'h00, 16'd10500, 16'h0000);
    send_tick(1'b1, 8'h00, 16'hFFFF,  16'h0000);
    send_tick(1'b0, 8'h80, 16'hFFFF,  16'h0000);
    send_tick(1'b0, 8'h00, 16'hFFFF,  16'h0000);
    send_tick(1'b0, 8'h01, 16'hFFFF,  16'h0000);
    send_tick(1'b1, 8'h00, 16'hFFFF,  16'h0000);
    send_tick(1'b1, 8'h00, 16'hFFFF,  16'h0000);
    send_tick(1'b0, 8'h00, 16'hFFFF,  16'hFFFF);
    send_tick(1'b0, 8'h00, 16'd0,     16'h0000);
    send_tick(1'b0, 8'h00, 16'hFFFF,  16'h0000);
    send_tick(1'b1, 8'hFF, 16'd0,     16'hFFFF);
    send_tick(1'b1, 8'h00, 16'd0,     16'h0000);
    send_tick(1'b1, 8'h00, 16'd20000, 16'h0000);
    send_tick(1'b0, 8'h00, 16'd20000, 16'h0001);
    settle();
    write_reg(REG_CHOREO_ENABLE, 16'd0);
    send_tick(1'b0, 8'hFF, 16'd20000, 16'h0000);
    send_tick(1'b0, 8'h00, 16'd20000, 16'h0000);
    send_tick(1'b0, 8'h01, 16'd20000, 16'h0000);
    send_tick(1'b0, 8'h00, 16'd20000, 16'h0000);
    settle();
    write_reg(REG_CHOREO_ENABLE, 16'd1);
  endtask

  task automatic test_choreography_episodes(input int count);
    repeat (count) offer_random_tick(20, 1'b1);
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) offer_random_tick(100, 1'b0);
  endtask

  task automatic test_choreo_toggle_mid_estop();
    int guard;
    guard = 0;
    while (!(cur_mode == MODE_ESTOP && dance_playing() && dance_step >= 16'd2) &&
           guard < 600) begin
      offer_random_tick(0, 1'b1);
      guard++;
    end
    settle();
    write_reg(REG_CHOREO_ENABLE, 16'd0);
    repeat (15) offer_random_tick(0, 1'b1);
    settle();
    write_reg(REG_CHOREO_ENABLE, 16'd1);
    repeat (60) offer_random_tick(0, 1'b1);
  endtask

  task automatic test_register_sweep();
    write_all_regs(16'd0, 8'h00, 16'hFFFF, 1'b0);
    test_random_traffic(80);
    write_all_regs(16'hFFFF, 8'hFF, 16'h0000, 1'b1);
    test_random_traffic(80);
    write_all_regs(16'($urandom), 8'($urandom), 16'($urandom), 1'b1);
    test_random_traffic(80);
    write_all_regs(16'($urandom), 8'($urandom), 16'($urandom), 1'b0);
    test_random_traffic(80);
    write_all_regs(BATTERY_THRESHOLD_RST, SENSOR_MASK_RST, DANGER_NONE_RST,
                   CHOREO_ENABLE_RST);
    test_choreography_episodes(80);
  endtask

  task automatic test_receiver_hold_off();
    hold_flip = ~hold_flip;
    repeat (40) offer_random_tick(100, 1'b0);
  endtask

  task automatic test_sender_pause();
    repeat (30) offer_random_tick(100, 1'b0);
    settle();
    repeat (30) offer_random_tick(20, 1'b1);
  endtask

  initial begin
    hold_flip = 1'b0;
    send_idle_pct = 19;
    recv_idle_pct = 80;
    rst            <= 1'b1;
    cfg_write_en   <= 1'b0;
    cfg_index      <= REG_BATTERY_THRESHOLD;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    start_button   <= 1'b0;
    sensor_bits    <= '0;
    battery_mv     <= '0;
    danger_flags   <= '0;
    model_reset();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_edges();
    test_choreography_episodes(150);
    test_random_traffic(200);
    test_choreo_toggle_mid_estop();

    settle();
    send_idle_pct = 80;
    recv_idle_pct = 19;
    test_register_sweep();
    test_choreography_episodes(150);
    test_random_traffic(150);

    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(250);
    test_receiver_hold_off();
    test_sender_pause();

    settle();
    if (tick_outcomes_q.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
